// ----- design/scd_pkg.sv -----
// Package for the scancode decoder: action codes, scancode constants and the key map.
// No dependencies; imported by the interfaces and the core.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned MapSize = 58;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [CharW-1:0] char_t;

  typedef enum logic [2:0] {
    ACT_CHAR      = 3'd0,
    ACT_SPACE     = 3'd1,
    ACT_BACKSPACE = 3'd2,
    ACT_TAB       = 3'd3,
    ACT_ENTER     = 3'd4,
    ACT_ZOOM_IN   = 3'd5,
    ACT_ZOOM_OUT  = 3'd6
  } action_t;

  localparam code_t SC_CAPS        = 8'h3A;
  localparam code_t SC_CTRL_MAKE   = 8'h1D;
  localparam code_t SC_CTRL_BREAK  = 8'h9D;
  localparam code_t SC_KP_PLUS     = 8'h35;
  localparam code_t SC_KP_MINUS    = 8'h1B;
  localparam code_t SC_SHIFT_MAKE  = 8'h2A;
  localparam code_t SC_SHIFT_BREAK = 8'hAA;
  localparam code_t SC_SPACE       = 8'h39;

  localparam char_t CH_BACKSPACE = 7'h08;
  localparam char_t CH_TAB       = 7'h09;
  localparam char_t CH_ENTER     = 7'h0A;
  localparam char_t CH_SPACE     = 7'h20;
  localparam char_t CH_NONE      = 7'h00;

  // Make codes below the map size to their unshifted ASCII; zero marks no key.
  function automatic char_t key_lookup(input code_t code);
    char_t ch;
    ch = CH_NONE;
    if (code < code_t'(MapSize)) begin
      unique case (code[5:0])
        6'd2:  ch = 7'h31;
        6'd3:  ch = 7'h32;
        6'd4:  ch = 7'h33;
        6'd5:  ch = 7'h34;
        6'd6:  ch = 7'h35;
        6'd7:  ch = 7'h36;
        6'd8:  ch = 7'h37;
        6'd9:  ch = 7'h38;
        6'd10: ch = 7'h39;
        6'd11: ch = 7'h30;
        6'd12: ch = 7'h2D;
        6'd13: ch = 7'h3D;
        6'd14: ch = CH_BACKSPACE;
        6'd15: ch = CH_TAB;
        6'd16: ch = 7'h71;
        6'd17: ch = 7'h77;
        6'd18: ch = 7'h65;
        6'd19: ch = 7'h72;
        6'd20: ch = 7'h74;
        6'd21: ch = 7'h79;
        6'd22: ch = 7'h75;
        6'd23: ch = 7'h69;
        6'd24: ch = 7'h6F;
        6'd25: ch = 7'h70;
        6'd26: ch = 7'h5B;
        6'd27: ch = 7'h2B;
        6'd28: ch = CH_ENTER;
        6'd29: ch = 7'h60;
        6'd30: ch = 7'h61;
        6'd31: ch = 7'h73;
        6'd32: ch = 7'h64;
        6'd33: ch = 7'h66;
        6'd34: ch = 7'h67;
        6'd35: ch = 7'h68;
        6'd36: ch = 7'h6A;
        6'd37: ch = 7'h6B;
        6'd38: ch = 7'h6C;
        6'd39: ch = 7'h3B;
        6'd40: ch = 7'h27;
        6'd41: ch = 7'h60;
        6'd43: ch = 7'h5C;
        6'd44: ch = 7'h7A;
        6'd45: ch = 7'h78;
        6'd46: ch = 7'h63;
        6'd47: ch = 7'h76;
        6'd48: ch = 7'h62;
        6'd49: ch = 7'h6E;
        6'd50: ch = 7'h6D;
        6'd53: ch = 7'h2D;
        6'd57: ch = CH_SPACE;
        default: ch = CH_NONE;
      endcase
    end
    return ch;
  endfunction

endpackage

// ----- design/scd_scan_if.sv -----
// Request channel carrying one scancode byte.
// Depends on scd_pkg.
`timescale 1ns / 1ps

interface scd_scan_if;
  import scd_pkg::*;

  logic  valid;
  logic  ready;
  code_t scancode;

  modport source (output valid, output scancode, input ready);
  modport sink (input valid, input scancode, output ready);
endinterface

// ----- design/scd_key_if.sv -----
// Request channel carrying one decoded key action and its character.
// Depends on scd_pkg.
`timescale 1ns / 1ps

interface scd_key_if;
  import scd_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  char_t   character;

  modport source (output valid, output action, output character, input ready);
  modport sink (input valid, input action, input character, output ready);
endinterface

// ----- design/scancode_to_ascii_decoder_core.sv -----
// Top level of the set-1 scancode to ASCII key decoder.
// Depends on scd_pkg, scd_scan_if and scd_key_if.
`timescale 1ns / 1ps

// Channel   Dir  Payload                       Meaning
// scan      in   scancode[7:0]                 raw set-1 byte, bit 7 = release
// key       out  action[2:0], character[6:0]   decoded key action
//
// One scancode per cycle while key is not stalled. A request is held in an input
// register, decoded in one pass against the modifier flags, and the result (if any)
// lands in the output register when the input register advances; key.valid is
// driven from the output register, so a scan request reaches key through both.
// Reset (rst, synchronous) empties both registers and clears caps, ctrl and shift.
// A stall on key holds the output register and, once the input register is
// also full, drops scan.ready; codes that give no result are dropped silently.

module scancode_to_ascii_decoder_core (
  input logic       clk,
  input logic       rst,
  scd_scan_if.sink   scan,
  scd_key_if.source  key
);
  import scd_pkg::*;

  // Input register.
  logic  stage_valid;
  code_t stage_code;

  // Modifier flags.
  logic caps_lock, caps_lock_next;
  logic ctrl_held, ctrl_held_next;
  logic shift_held, shift_held_next;

  // Output register.
  logic    out_valid;
  action_t out_action;
  char_t   out_character;

  logic    advance;
  logic    hit;
  action_t hit_action;
  char_t   hit_character;
  char_t   map_ch;

  // Advance the input register whenever the output register is free or drains.
  assign advance    = stage_valid && (!out_valid || key.ready);
  assign scan.ready = !stage_valid || advance;

  assign key.valid     = out_valid;
  assign key.action    = out_action;
  assign key.character = out_character;

  // Decode: flags first (caps, ctrl, then shift), zoom with the updated ctrl,
  // then the key map.
  always_comb begin
    caps_lock_next  = caps_lock ^ (stage_code == SC_CAPS);
    ctrl_held_next  = ctrl_held;
    shift_held_next = shift_held;
    if (stage_code == SC_CTRL_MAKE) begin
      ctrl_held_next = 1'b1;
    end else if (stage_code == SC_CTRL_BREAK) begin
      ctrl_held_next = 1'b0;
    end
    if (stage_code == SC_SHIFT_MAKE) begin
      shift_held_next = 1'b1;
    end else if (stage_code == SC_SHIFT_BREAK) begin
      shift_held_next = 1'b0;
    end

    map_ch        = key_lookup(stage_code);
    hit           = 1'b1;
    hit_action    = ACT_CHAR;
    hit_character = map_ch;

    if (ctrl_held_next && stage_code == SC_KP_PLUS) begin
      hit_action    = ACT_ZOOM_IN;
      hit_character = CH_NONE;
    end else if (ctrl_held_next && stage_code == SC_KP_MINUS) begin
      hit_action    = ACT_ZOOM_OUT;
      hit_character = CH_NONE;
    end else if (stage_code == SC_SPACE) begin
      hit_action    = ACT_SPACE;
      hit_character = CH_SPACE;
    end else if (map_ch == CH_BACKSPACE) begin
      hit_action = ACT_BACKSPACE;
    end else if (map_ch == CH_TAB) begin
      hit_action = ACT_TAB;
    end else if (map_ch == CH_ENTER) begin
      hit_action = ACT_ENTER;
    end else if (map_ch == CH_NONE || ctrl_held_next) begin
      // Drop unmapped codes, releases and plain keys under ctrl.
      hit = 1'b0;
    end else if ((shift_held_next ^ caps_lock_next)
                 && map_ch >= 7'h61 && map_ch <= 7'h7A) begin
      // Upper-case letters only: clear the 0x20 bit.
      hit_character = map_ch & ~7'h20;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      caps_lock   <= 1'b0;
      ctrl_held   <= 1'b0;
      shift_held  <= 1'b0;
    end else begin
      if (scan.valid && scan.ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end

      if (advance) begin
        caps_lock  <= caps_lock_next;
        ctrl_held  <= ctrl_held_next;
        shift_held <= shift_held_next;
        out_valid  <= hit;
      end else if (key.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      stage_code <= scan.scancode;
    end
    if (advance && hit) begin
      out_action    <= hit_action;
      out_character <= hit_character;
    end
  end

endmodule

// ----- tb/scd_tb_pkg.sv -----
// Scoreboard for the scancode decoder testbench: key map, modifier flags and request checks.
// Depends on scd_pkg for the action codes, scancode constants and field types.
`timescale 1ns / 1ps

package scd_tb_pkg;
  import scd_pkg::*;

  typedef struct packed {
    action_t action;
    char_t   character;
  } key_req_t;

  localparam char_t LowerA   = 7'h61;
  localparam char_t LowerZ   = 7'h7A;
  localparam char_t CaseGap  = 7'h20;

  // Unshifted ASCII for each make code below the map size; zero marks no key.
  localparam char_t KEY_CHARS [MapSize] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h2B, 7'h0A, 7'h60,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h20
  };

  class key_scoreboard;
    bit          caps_on;
    bit          ctrl_down;
    bit          shift_down;
    key_req_t    awaited[$];
    int unsigned fail_count;

    function new();
      caps_on    = 1'b0;
      ctrl_down  = 1'b0;
      shift_down = 1'b0;
      fail_count = 0;
    endfunction

    // Advance the modifier flags and queue the key request this code causes.
    function void note_scancode(input code_t code);
      key_req_t want;
      char_t    ch;
      bit       hit;
      hit    = 1'b1;
      ch     = CH_NONE;
      if (code == SC_CAPS) caps_on = !caps_on;
      if (code == SC_CTRL_MAKE) ctrl_down = 1'b1;
      else if (code == SC_CTRL_BREAK) ctrl_down = 1'b0;
      if (code == SC_SHIFT_MAKE) shift_down = 1'b1;
      else if (code == SC_SHIFT_BREAK) shift_down = 1'b0;
      if (code < MapSize) ch = KEY_CHARS[code[5:0]];

      if (ctrl_down && code == SC_KP_PLUS) begin
        want.action = ACT_ZOOM_IN;  want.character = CH_NONE;
      end else if (ctrl_down && code == SC_KP_MINUS) begin
        want.action = ACT_ZOOM_OUT; want.character = CH_NONE;
      end else if (code == SC_SPACE) begin
        want.action = ACT_SPACE;    want.character = CH_SPACE;
      end else if (ch == CH_BACKSPACE) begin
        want.action = ACT_BACKSPACE; want.character = CH_BACKSPACE;
      end else if (ch == CH_TAB) begin
        want.action = ACT_TAB;      want.character = CH_TAB;
      end else if (ch == CH_ENTER) begin
        want.action = ACT_ENTER;    want.character = CH_ENTER;
      end else if (ch != CH_NONE && !ctrl_down) begin
        // Flip case for letters only
        if ((shift_down != caps_on) && ch >= LowerA && ch <= LowerZ) ch = ch - CaseGap;
        want.action = ACT_CHAR;     want.character = ch;
      end else begin
        hit = 1'b0;
      end

      if (hit) awaited.push_back(want);
    endfunction

    task report(input string msg);
      fail_count++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_key(input action_t act, input char_t ch);
      key_req_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected key request action %0d char 0x%02h", act, ch));
        return;
      end
      want = awaited.pop_front();
      if (act !== want.action)
        report($sformatf("action %0d, wanted %0d", act, want.action));
      if (ch !== want.character)
        report($sformatf("character 0x%02h, wanted 0x%02h", ch, want.character));
    endtask

    task drain_check();
      if (awaited.size() != 0)
        report($sformatf("%0d key requests never arrived", awaited.size()));
    endtask
  endclass

endpackage

// ----- tb/tb_scancode_to_ascii_decoder_core.sv -----
// Top of the scancode decoder testbench: clock, reset, drivers, monitor and end of run.
// Depends on scd_pkg, scd_tb_pkg, scd_scan_if, scd_key_if and the decoder core.
`timescale 1ns / 1ps

module tb_scancode_to_ascii_decoder_core;
  import scd_pkg::*;
  import scd_tb_pkg::*;

  // Count of accepted scancode requests before the stimulus stops
  localparam int unsigned ItemTarget      = 1150;
  // Final stretch of the run with no idling on either side
  localparam int unsigned CalmTail        = 150;
  localparam longint unsigned CycleLimit  = 400000;
  // Margin after the last awaited request before the final check
  localparam int unsigned DrainCycles     = 8;

  // Directed opening: extremes, each action, case handling and the ctrl special cases
  localparam code_t DirectedCodes [25] = '{
    8'h00, 8'hFF, 8'h1E, 8'h02, SC_SHIFT_MAKE,     // unmapped, break, 'a', '1', shift on
    8'h1E, 8'h0D, SC_CAPS, 8'h2C, SC_SHIFT_BREAK,  // 'A', '=' kept, caps on, 'z', shift off
    8'h10, 8'h1A, SC_CAPS, SC_KP_PLUS, SC_KP_MINUS, // 'Q', '[' kept, caps off, '-', '+'
    SC_CTRL_MAKE, SC_KP_PLUS, SC_KP_MINUS, 8'h1E,  // ctrl on, zoom in, zoom out, 'a' muted
    SC_SPACE, 8'h0E, 8'h0F, 8'h1C, SC_CTRL_BREAK,  // space, backspace, tab, enter under ctrl
    8'h80                                          // plain break code
  };

  // Ctrl break is weighted up so that ctrl is not held for most of the run
  localparam code_t ModifierCodes [6] = '{
    SC_CAPS, SC_CTRL_MAKE, SC_CTRL_BREAK, SC_CTRL_BREAK, SC_SHIFT_MAKE, SC_SHIFT_BREAK
  };

  logic clk;
  logic rst;

  scd_scan_if scan();
  scd_key_if  key();

  scancode_to_ascii_decoder_core i_dut (
    .clk (clk),
    .rst (rst),
    .scan(scan),
    .key (key)
  );

  key_scoreboard board;
  int unsigned   sent_count = 0;
  longint unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idling is allowed in most windows of the run, never in the calm tail
  function automatic bit idle_allowed();
    return (sent_count + CalmTail < ItemTarget) && ((sent_count % 250) < 190);
  endfunction

  // Weight the random codes towards real make codes, modifiers and zoom keys
  function automatic code_t pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return code_t'($urandom_range(0, MapSize - 1));
    if (roll < 65) return ModifierCodes[$urandom_range(0, 5)];
    if (roll < 75) return ($urandom_range(0, 1) != 0) ? SC_KP_PLUS : SC_KP_MINUS;
    if (roll < 83) return code_t'($urandom_range(8'h80, 8'hFF));
    return code_t'($urandom_range(0, 255));
  endfunction

  // Offer one scancode request, optionally after a gap, and hold it until accepted.
  // Called and returns at a falling edge.
  task automatic send_code(input code_t code);
    if (idle_allowed() && $urandom_range(0, 3) == 0) begin
      scan.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    scan.valid    <= 1'b1;
    scan.scancode <= code;
    @(posedge clk);
    while (!scan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Key side: stall in random bursts, otherwise keep ready high
  initial begin
    key.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_allowed() && $urandom_range(0, 4) == 0) begin
        key.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      key.ready <= 1'b1;
    end
  end

  // Monitor: note accepted scancodes, check accepted key requests in order
  always @(posedge clk) begin
    if (!rst) begin
      if (scan.valid && scan.ready) begin
        board.note_scancode(scan.scancode);
        sent_count <= sent_count + 1;
      end
      if (key.valid && key.ready)
        board.check_key(key.action, key.character);
    end
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    board         = new();
    rst           = 1'b1;
    scan.valid    = 1'b0;
    scan.scancode = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DirectedCodes[i]) send_code(DirectedCodes[i]);
    while (sent_count < ItemTarget) send_code(pick_code());
    scan.valid <= 1'b0;

    // Drain: wait for every awaited request, then let the pipeline settle
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    board.drain_check();

    if (board.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
